@@ hdl/chd_pkg.sv @@
// ---------------------------------------------------------------------------
// chd_pkg - shared types for the chunked body decoder
// Request payloads, the classified byte handed from front to back, and the
// depth of the queue that sits between the two.
// ---------------------------------------------------------------------------
package chd_pkg;

    localparam int LEN_W    = 26;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } chd_in_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             out_data;
        logic             out_end;
        logic             out_terminated;
        logic [LEN_W-1:0] out_length;
    } chd_out_t;

    // Byte after classification by the front end
    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_ws;
    } chd_item_t;

endpackage

@@ hdl/chd_front.sv @@
// ---------------------------------------------------------------------------
// chd_front - request intake and byte classification
// Accepts a byte request when the queue has room and tags it as hex digit,
// CR, LF or blank so the back end sees one-bit flags and the digit value.
// ---------------------------------------------------------------------------
module chd_front
    import chd_pkg::*;
(
    input  logic      src_valid,
    output logic      src_stall,
    input  chd_in_t   src_item,
    input  logic      q_full,
    output logic      q_push,
    output chd_item_t q_item
);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HX = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    logic [7:0] b;
    logic       is_dec;
    logic       is_alpha;

    assign b        = src_item.in_byte;
    assign is_dec   = (b >= CH_0) && (b <= CH_9);
    assign is_alpha = ((b >= CH_LA) && (b <= CH_LF_HX)) || ((b >= CH_UA) && (b <= CH_UF));

    assign src_stall = q_full;
    assign q_push    = src_valid && !q_full;

    always_comb
    begin
        q_item.byte_val = b;
        q_item.last     = src_item.in_last;
        q_item.is_hex   = is_dec || is_alpha;
        // letters a-f and A-F share the low nibble 1..6
        q_item.hex_val  = is_dec ? b[3:0] : (b[3:0] + 4'd9);
        q_item.is_cr    = (b == CH_CR);
        q_item.is_lf    = (b == CH_LF);
        q_item.is_ws    = (b == CH_SP) || (b == CH_TAB);
    end

endmodule

@@ hdl/chd_queue.sv @@
// ---------------------------------------------------------------------------
// chd_queue - short queue between front and back
// Register-based FIFO of classified bytes; push and pop in the same cycle.
// ---------------------------------------------------------------------------
module chd_queue
    import chd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  chd_item_t push_item,
    input  logic      pop,
    output logic      not_empty,
    output logic      full,
    output chd_item_t head_item
);

    chd_item_t         mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hdl/chd_back.sv @@
// ---------------------------------------------------------------------------
// chd_back - chunk framing state machine and result register
// Walks size lines, chunk data and trailing CR LF, counts payload bytes
// and holds one result request until the sink takes it.
// ---------------------------------------------------------------------------
module chd_back
    import chd_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int MAX_BODY  = 33554432
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  chd_item_t q_item,
    output logic      q_pop,
    output logic      res_valid,
    input  logic      res_stall,
    output chd_out_t  res_item
);

    localparam int CNT_W = $clog2(MAX_BODY + 1);
    localparam logic [SIZE_BITS-1:0] SIZE_MAX = '1;

    typedef enum logic [4:0] {
        PH_SIZE     = 5'b00001,
        PH_DATA     = 5'b00010,
        PH_AFTER    = 5'b00100,
        PH_AFTER_CR = 5'b01000,
        PH_DONE     = 5'b10000
    } phase_t;

    typedef enum logic [2:0] {
        HX_LEAD   = 3'b001,
        HX_DIGITS = 3'b010,
        HX_STOP   = 3'b100
    } hex_phase_t;

    typedef struct packed {
        logic                 done;
        hex_phase_t           hp;
        logic [SIZE_BITS-1:0] csz;
        logic                 pcr;
    } sb_t;

    phase_t               phase_reg;
    phase_t               phase_next;
    hex_phase_t           hp_reg;
    hex_phase_t           hp_next;
    logic [SIZE_BITS-1:0] csz_reg;
    logic [SIZE_BITS-1:0] csz_next;
    logic                 pcr_reg;
    logic                 pcr_next;
    logic [SIZE_BITS-1:0] left_reg;
    logic [SIZE_BITS-1:0] left_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 res_valid_reg;
    chd_out_t             res_item_reg;

    hex_phase_t           base_hp;
    logic [SIZE_BITS-1:0] base_csz;
    logic                 base_pcr;
    sb_t                  sb;
    logic [SIZE_BITS-1:0] left_dec;
    logic                 have;
    logic                 data;
    logic                 term;
    logic                 drop;

    // One size-line byte: leading blanks, hex digits, then stop; CR LF ends it.
    function automatic sb_t size_byte(hex_phase_t hp, logic [SIZE_BITS-1:0] csz,
                                      logic pcr, chd_item_t it);
        sb_t r;
        r.done = 1'b0;
        r.hp   = hp;
        r.csz  = csz;
        r.pcr  = pcr;
        if (pcr && it.is_lf)
        begin
            r.done = 1'b1;
        end
        else
        begin
            r.pcr = it.is_cr;
            if (!(hp == HX_LEAD && it.is_ws))
            begin
                if (hp == HX_LEAD)
                begin
                    r.hp = it.is_hex ? HX_DIGITS : HX_STOP;
                end
                else if (hp == HX_DIGITS && !it.is_hex)
                begin
                    r.hp = HX_STOP;
                end
                if (r.hp == HX_DIGITS && it.is_hex)
                begin
                    // saturate once a digit would shift bits out the top
                    if (csz[SIZE_BITS-1 -: 4] != 4'd0)
                    begin
                        r.csz = SIZE_MAX;
                    end
                    else
                    begin
                        r.csz = {csz[SIZE_BITS-5:0], it.hex_val};
                    end
                end
            end
        end
        return r;
    endfunction

    assign q_pop     = q_valid && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;
    assign left_dec  = (left_reg != '0) ? (left_reg - 1'b1) : left_reg;

    always_comb
    begin
        base_hp  = hp_reg;
        base_csz = csz_reg;
        base_pcr = pcr_reg;
        if (phase_reg == PH_AFTER)
        begin
            base_hp  = HX_LEAD;
            base_csz = '0;
            base_pcr = 1'b0;
        end
        else if (phase_reg == PH_AFTER_CR)
        begin
            // CR without LF: the new size line has already stopped parsing
            base_hp  = HX_STOP;
            base_csz = '0;
            base_pcr = 1'b0;
        end
    end

    assign sb = size_byte(base_hp, base_csz, base_pcr, q_item);

    always_comb
    begin
        phase_next = phase_reg;
        hp_next    = hp_reg;
        csz_next   = csz_reg;
        pcr_next   = pcr_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        have       = 1'b0;
        data       = 1'b0;
        term       = 1'b0;
        unique case (phase_reg)
            PH_DATA:
            begin
                data = 1'b1;
                have = 1'b1;
                if (cnt_reg < CNT_W'(MAX_BODY))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = PH_AFTER;
                end
            end
            PH_AFTER:
            begin
                if (q_item.is_cr)
                begin
                    phase_next = PH_AFTER_CR;
                end
                else
                begin
                    phase_next = PH_SIZE;
                    hp_next    = sb.hp;
                    csz_next   = sb.csz;
                    pcr_next   = sb.pcr;
                end
            end
            PH_AFTER_CR:
            begin
                phase_next = PH_SIZE;
                if (q_item.is_lf)
                begin
                    hp_next  = HX_LEAD;
                    csz_next = '0;
                    pcr_next = 1'b0;
                end
                else
                begin
                    hp_next  = sb.hp;
                    csz_next = sb.csz;
                    pcr_next = sb.pcr;
                end
            end
            PH_DONE:
            begin
                // drop everything until the buffer ends
            end
            PH_SIZE:
            begin
                if (sb.done)
                begin
                    if (csz_reg == '0)
                    begin
                        phase_next = PH_DONE;
                        term       = 1'b1;
                        have       = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        left_next  = csz_reg;
                        pcr_next   = 1'b0;
                    end
                end
                else
                begin
                    hp_next  = sb.hp;
                    csz_next = sb.csz;
                    pcr_next = sb.pcr;
                end
            end
            default:
            begin
                phase_next = PH_SIZE;
            end
        endcase

        drop = q_item.last && (phase_next == PH_DONE) && !term;
        if (q_item.last)
        begin
            have       = !drop;
            phase_next = PH_SIZE;
            hp_next    = HX_LEAD;
            csz_next   = '0;
            pcr_next   = 1'b0;
            left_next  = '0;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SIZE;
            hp_reg        <= HX_LEAD;
            csz_reg       <= '0;
            pcr_reg       <= 1'b0;
            left_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg     <= phase_next;
                hp_reg        <= hp_next;
                csz_reg       <= csz_next;
                pcr_reg       <= pcr_next;
                left_reg      <= left_next;
                cnt_reg       <= cnt_next;
                res_valid_reg <= have;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Length reports the count before any end-of-buffer reset
    always_ff @(posedge clk)
    begin
        if (q_pop && have)
        begin
            res_item_reg.out_byte       <= data ? q_item.byte_val : 8'd0;
            res_item_reg.out_data       <= data;
            res_item_reg.out_end        <= term || q_item.last;
            res_item_reg.out_terminated <= term;
            res_item_reg.out_length     <= LEN_W'((phase_reg == PH_DATA &&
                                                   cnt_reg < CNT_W'(MAX_BODY))
                                                  ? cnt_reg + 1'b1 : cnt_reg);
        end
    end

endmodule

@@ hdl/http_chunked_body_decoder_top.sv @@
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_top - chunked transfer body decoder
// Strips size lines and CR LF framing from a chunked body; passes on payload
// bytes and end results with a running length and end/terminated flags.
//
//   channel  valid      stall      payload                 direction
//   src      src_valid  src_stall  src_item (chd_in_t)     into block
//   res      res_valid  res_stall  res_item (chd_out_t)    out of block
//
// One byte per cycle sustained while the result side is not stalled; the
// back end computes its next framing state combinationally, so a new byte
// can be taken every clock. An accepted byte passes through the queue and
// then the result register. Framing bytes produce no result request unless
// they close the zero-size line or carry the last flag. Reset clears the
// queue, the framing state and the result valid flag. A stalled result holds
// the back end; the two-entry queue then fills and src_stall rises.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_top
    import chd_pkg::*;
#(
    parameter int SIZE_BITS = 32,
    parameter int MAX_BODY  = 33554432
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  chd_in_t  src_item,
    output logic     res_valid,
    input  logic     res_stall,
    output chd_out_t res_item
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_not_empty;
    chd_item_t q_in_item;
    chd_item_t q_head_item;

    chd_front u_front (
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in_item)
    );

    chd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head_item (q_head_item)
    );

    chd_back #(
        .SIZE_BITS (SIZE_BITS),
        .MAX_BODY  (MAX_BODY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_item    (q_head_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

@@ tb/tb_http_chunked_body_decoder_top.sv @@
// ---------------------------------------------------------------------------
// tb_http_chunked_body_decoder_top - self-checking bench for the chunk decoder
// Feeds chunked bodies byte by byte: a few hand-built framing cases first,
// then random bodies (mostly well formed, some broken or noisy, some cut
// short by the last flag). A bench-side copy of the framing state predicts
// every result, and each accepted result is compared field by field. Both
// channels idle at random; the receiver also holds off for a long stretch.
// ---------------------------------------------------------------------------
module tb_http_chunked_body_decoder_top;
    import chd_pkg::*;

    localparam int SZ_BITS     = 32;
    localparam int LEN_CAP     = 33554432;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES = 150;

    localparam logic [7:0] CR  = 8'h0D;
    localparam logic [7:0] LF  = 8'h0A;
    localparam logic [7:0] SP  = 8'h20;
    localparam logic [7:0] TAB = 8'h09;

    localparam logic [SZ_BITS-1:0] SIZE_MAX = '1;

    typedef enum logic [2:0] {SZ_LINE, IN_DATA, AFTER_DATA, AFTER_CR, BODY_DONE} frame_t;
    typedef enum logic [1:0] {HEX_LEAD, HEX_DIGITS, HEX_STOP} hex_t;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    chd_in_t  src_item = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    chd_out_t res_item;

    // framing state of the predictor
    frame_t             frame;
    hex_t               hexst;
    logic               cr_seen;
    logic [SZ_BITS-1:0] chunk;
    logic [SZ_BITS-1:0] data_rem;
    logic [LEN_W-1:0]   emitted;

    chd_in_t    tx_bytes[$];
    chd_out_t   decoded_q[$];
    logic [7:0] body_bytes[$];

    int  n_pushed   = 0;
    int  n_accepted = 0;
    int  n_errors   = 0;
    int  cycles     = 0;
    bit  src_taken  = 1'b0;
    int  src_gap    = 0;
    int  src_run    = 0;
    int  res_gap    = 0;
    int  res_run    = 0;
    int  hold_req   = 0;
    int  hold_seen  = 0;
    int  hold_left  = 0;

    http_chunked_body_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic void new_line();
        frame   = SZ_LINE;
        chunk   = '0;
        hexst   = HEX_LEAD;
        cr_seen = 1'b0;
    endfunction

    function automatic void reset_decoder();
        new_line();
        data_rem = '0;
        emitted  = '0;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // Feed one size-line byte; return 1 when CR LF closes the line.
    function automatic bit line_byte(input logic [7:0] c);
        int d;
        logic [SZ_BITS+3:0] v;
        if (cr_seen && c == LF) return 1'b1;
        cr_seen = (c == CR);
        d = hex_digit(c);
        if (hexst == HEX_LEAD)
        begin
            if (c == SP || c == TAB) return 1'b0;
            hexst = (d >= 0) ? HEX_DIGITS : HEX_STOP;
        end
        else if (hexst == HEX_DIGITS && d < 0)
        begin
            hexst = HEX_STOP;
        end
        if (hexst == HEX_DIGITS && d >= 0)
        begin
            if (chunk > (SIZE_MAX >> 4))
            begin
                chunk = SIZE_MAX;
            end
            else
            begin
                v = ({4'b0, chunk} << 4) + (SZ_BITS + 4)'(d);
                chunk = (v > {4'b0, SIZE_MAX}) ? SIZE_MAX : v[SZ_BITS-1:0];
            end
        end
        return 1'b0;
    endfunction

    function automatic void decode_byte(input chd_in_t it);
        logic [7:0] c;
        bit         have;
        bit         data;
        bit         term;
        chd_out_t   r;
        c    = it.in_byte;
        have = 1'b0;
        data = 1'b0;
        term = 1'b0;
        case (frame)
            IN_DATA:
            begin
                data = 1'b1;
                have = 1'b1;
                if (emitted < LEN_CAP) emitted++;
                if (data_rem > 0) data_rem--;
                if (data_rem == 0) frame = AFTER_DATA;
            end
            AFTER_DATA:
            begin
                if (c == CR)
                begin
                    frame = AFTER_CR;
                end
                else
                begin
                    new_line();
                    void'(line_byte(c));
                end
            end
            AFTER_CR:
            begin
                new_line();
                // CR not followed by LF: the new size line is already stopped
                if (c != LF)
                begin
                    hexst = HEX_STOP;
                    void'(line_byte(c));
                end
            end
            BODY_DONE: ;
            default:
            begin
                if (line_byte(c))
                begin
                    if (chunk == 0)
                    begin
                        frame = BODY_DONE;
                        term  = 1'b1;
                        have  = 1'b1;
                    end
                    else
                    begin
                        frame    = IN_DATA;
                        data_rem = chunk;
                        cr_seen  = 1'b0;
                    end
                end
            end
        endcase
        if (it.in_last && frame == BODY_DONE && !term)
        begin
            reset_decoder();
            return;
        end
        if (it.in_last) have = 1'b1;
        if (!have) return;
        r.out_byte       = data ? c : 8'h00;
        r.out_data       = data;
        r.out_end        = term || it.in_last;
        r.out_terminated = term;
        r.out_length     = emitted;
        decoded_q.push_back(r);
        if (it.in_last) reset_decoder();
    endfunction

    // Mostly no gap, some short, a few long, with occasional gap-free runs.
    function automatic int idle_len(inout int run_left);
        int r;
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            run_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put(input logic [7:0] b, input bit last);
        chd_in_t it;
        it.in_byte = b;
        it.in_last = last;
        tx_bytes.push_back(it);
        n_pushed++;
    endfunction

    function automatic void put_text(input string s, input bit last_on_end);
        for (int i = 0; i < s.len(); i++) put(s[i], last_on_end && i == s.len() - 1);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    task automatic queue_random_body();
        int kind;
        int sz;
        int ndig;
        int cut;
        int r;
        body_bytes.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            // noise with plenty of framing bytes
            repeat ($urandom_range(1, 30))
            begin
                r = $urandom_range(0, 3);
                body_bytes.push_back(r == 0 ? CR : r == 1 ? LF : 8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 11)
        begin
            // more size digits than the size width holds: mostly saturates, rest of the body is payload
            repeat ($urandom_range(9, 14)) body_bytes.push_back(hex_char($urandom_range(0, 15)));
            add_text("\r\n");
            repeat ($urandom_range(1, 6)) body_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
            begin
                sz = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 80);
                if ($urandom_range(0, 4) == 0)
                begin
                    repeat ($urandom_range(1, 2)) body_bytes.push_back($urandom_range(0, 1) ? SP : TAB);
                end
                if ($urandom_range(0, 9) == 0) add_text("00");
                ndig = 1;
                while ((sz >> (4 * ndig)) != 0) ndig++;
                for (int i = ndig - 1; i >= 0; i--) body_bytes.push_back(hex_char((sz >> (4 * i)) & 15));
                case ($urandom_range(0, 9))
                    0: add_text(";x=1");
                    1: add_text("\n");
                    2: add_text(" ;q");
                    default: ;
                endcase
                add_text("\r\n");
                repeat (sz) body_bytes.push_back(8'($urandom_range(0, 255)));
                r = $urandom_range(0, 99);
                if (r < 85)
                begin
                    add_text("\r\n");
                end
                else if (r < 93)
                begin
                    body_bytes.push_back(CR);
                    body_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            case ($urandom_range(0, 3))
                0: add_text("0");
                1: add_text("000");
                2: add_text(" \t0");
                default: add_text("0;end");
            endcase
            add_text("\r\n");
            if ($urandom_range(0, 2) != 0)
            begin
                repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        cut = body_bytes.size() - 1;
        if (kind >= 11 && $urandom_range(0, 4) == 0) cut = $urandom_range(0, cut);
        for (int i = 0; i <= cut; i++) put(body_bytes[i], i == cut);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (n_errors < 50)
        begin
            $display("cycle %0d: %s got 0x%0h, expected 0x%0h", cycles, what, got, want);
        end
        n_errors++;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || decoded_q.size() != 0) @(posedge clk);
    endtask

    // Request driver: hold a stalled request, otherwise advance after the gap.
    always @(negedge clk)
    begin : drive_src
        chd_in_t nxt_item;
        logic    nxt_valid;
        nxt_item  = src_item;
        nxt_valid = src_valid;
        if (!rst_n)
        begin
            nxt_valid = 1'b0;
        end
        else if (!src_valid || src_taken)
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                nxt_valid = 1'b0;
            end
            else if (tx_bytes.size() > 0)
            begin
                nxt_item  = tx_bytes.pop_front();
                nxt_valid = 1'b1;
                src_gap   = idle_len(src_run);
            end
            else
            begin
                nxt_valid = 1'b0;
            end
        end
        src_item  <= nxt_item;
        src_valid <= nxt_valid;
    end

    always @(negedge clk)
    begin : drive_res
        logic nxt;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            nxt = 1'b1;
        end
        else if (res_gap > 0)
        begin
            res_gap--;
            nxt = 1'b1;
        end
        else
        begin
            nxt = 1'b0;
            res_gap = idle_len(res_run);
        end
        res_stall <= nxt;
    end

    always @(posedge clk)
    begin : watch
        chd_out_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
        else
        begin
            src_taken = rst_n && src_valid && !src_stall;
            if (src_taken)
            begin
                n_accepted++;
                decode_byte(src_item);
            end
            if (rst_n && res_valid && !res_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    report("unexpected result, out_length", 32'(res_item.out_length), 0);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (res_item.out_byte !== want.out_byte)
                        report("out_byte", 32'(res_item.out_byte), 32'(want.out_byte));
                    if (res_item.out_data !== want.out_data)
                        report("out_data", 32'(res_item.out_data), 32'(want.out_data));
                    if (res_item.out_end !== want.out_end)
                        report("out_end", 32'(res_item.out_end), 32'(want.out_end));
                    if (res_item.out_terminated !== want.out_terminated)
                        report("out_terminated", 32'(res_item.out_terminated),
                               32'(want.out_terminated));
                    if (res_item.out_length !== want.out_length)
                        report("out_length", 32'(res_item.out_length), 32'(want.out_length));
                end
            end
        end
    end

    initial
    begin : stimulus
        int target;
        reset_decoder();
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // padded size line with extension, zero byte of payload
        put_text(" \t1;e\r\n", 1'b0);
        put(8'h00, 1'b0);
        // lone LF inside a size line, all-ones payload byte
        put_text("\r\n1\n\r\n", 1'b0);
        put(8'hFF, 1'b0);
        // CR without LF after data gives a zero size line, then trailing bytes
        put_text("\rx\r\n", 1'b0);
        put_text("ZQ", 1'b1);
        // last flag on a size line, then on a payload byte
        put_text("A", 1'b1);
        put_text("2\r\nk", 1'b1);
        wait_drained();

        target = n_pushed + RANDOM_ITEMS / 2;
        while (n_pushed < target) queue_random_body();
        // sender keeps offering while the receiver holds off
        hold_req++;
        wait_drained();

        target = n_pushed + RANDOM_ITEMS / 2;
        while (n_pushed < target) queue_random_body();
        wait_drained();

        repeat (20) @(posedge clk);
        if (n_errors == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
